// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the lock table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define LKT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define LKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lkt_pkg.sv =====
// Types and constants of the lock table.
package lkt_pkg;

  localparam int MAX_IDS     = 8;
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_W       = 64;
  localparam int SCAN_LEN    = (TABLE_DEPTH > MAX_IDS) ? TABLE_DEPTH : MAX_IDS;

  localparam int TW  = $clog2(TABLE_DEPTH);
  localparam int PW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int PCW = $clog2(MAX_IDS + 1);
  localparam int FW  = $clog2(TABLE_DEPTH + 1);
  localparam int CW  = $clog2(SCAN_LEN + 1);
  localparam int NW  = (FW > PCW) ? FW : PCW;

  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STATUS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } lkt_op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CONFLICT = 2'd1,
    STATUS_FULL     = 2'd2
  } lkt_status_t;

  typedef struct packed {
    lkt_op_t          op;
    logic [KEY_W-1:0] key;
    logic             last;
  } lkt_cmd_t;

  typedef struct packed {
    logic        valid;
    lkt_status_t status;
  } lkt_res_t;

endpackage

// ===== hw/rtl/lkt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lkt_engine.sv =====
// Lock table engine: key memory scan, pending buffer and all-or-nothing commit.
`include "assert_macros.svh"

module lkt_engine
  import lkt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  lkt_cmd_t cmd,
  output logic     idle,
  output lkt_res_t res,
  input  logic     res_ack
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_FIN    = 6'b000100,
    ST_INS_RD = 6'b001000,
    ST_INS_WR = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t            state;
  lkt_cmd_t          cmd_q;
  logic [CW-1:0]     scan_cnt;
  logic              chk_tbl;
  logic              chk_pnd;
  logic [TW-1:0]     tbl_idx_d;
  logic              dup_acc;
  logic [PCW-1:0]    pending_count;
  logic [PCW-1:0]    distinct_count;
  logic              conflict_seen;
  logic [FW-1:0]     free_count;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [MAX_IDS-1:0]     dup_flag;
  logic [PCW-1:0]    ins_p;
  logic [TW-1:0]     ins_t;
  lkt_status_t       status_q;

  logic              issue;
  logic              tbl_re;
  logic              tbl_we;
  logic              pnd_re;
  logic              pnd_re_scan;
  logic              pnd_we;
  logic [PW-1:0]     pnd_raddr;
  logic [KEY_W-1:0]  tbl_rd_data;
  logic [KEY_W-1:0]  pnd_rd_data;
  logic              tbl_hit;
  logic              pnd_hit;
  logic              scan_end;
  logic              ins_dup;
  logic              is_dup;

  always_comb begin
    issue       = scan_cnt < CW'(SCAN_LEN);
    tbl_re      = (state == ST_SCAN) && issue && (scan_cnt < CW'(TABLE_DEPTH));
    pnd_re_scan = (state == ST_SCAN) && issue && (scan_cnt < CW'(pending_count));
    pnd_re      = pnd_re_scan ||
                  ((state == ST_INS_RD) && (ins_p != pending_count));
    pnd_raddr   = (state == ST_SCAN) ? scan_cnt[PW-1:0] : ins_p[PW-1:0];
    scan_end    = (state == ST_SCAN) && !issue;
    pnd_we      = scan_end;
    tbl_hit     = chk_tbl && entry_valid[tbl_idx_d] && (tbl_rd_data == cmd_q.key);
    pnd_hit     = chk_pnd && (pnd_rd_data == cmd_q.key);
    is_dup      = dup_acc || pnd_hit;
    ins_dup     = dup_flag[ins_p[PW-1:0]];
    tbl_we      = (state == ST_INS_WR) && !ins_dup && !entry_valid[ins_t];
  end

  lkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ins_t),
    .wdata (pnd_rd_data),
    .re    (tbl_re),
    .raddr (scan_cnt[TW-1:0]),
    .rdata (tbl_rd_data)
  );

  lkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_IDS)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pnd_we),
    .waddr (pending_count[PW-1:0]),
    .wdata (cmd_q.key),
    .re    (pnd_re),
    .raddr (pnd_raddr),
    .rdata (pnd_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_cnt       <= '0;
      chk_tbl        <= 1'b0;
      chk_pnd        <= 1'b0;
      dup_acc        <= 1'b0;
      pending_count  <= '0;
      distinct_count <= '0;
      conflict_seen  <= 1'b0;
      free_count     <= FW'(TABLE_DEPTH);
      entry_valid    <= '0;
      ins_p          <= '0;
      ins_t          <= '0;
      status_q       <= STATUS_OK;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q    <= cmd;
            scan_cnt <= '0;
            chk_tbl  <= 1'b0;
            chk_pnd  <= 1'b0;
            dup_acc  <= 1'b0;
            if (pending_count < PCW'(MAX_IDS)) begin
              state <= ST_SCAN;
            end else if (cmd.last) begin
              // identifier beyond the limit: only closes the request
              state <= ST_FIN;
            end
          end
        end
        ST_SCAN: begin
          // one entry issued per cycle, compared in the next cycle
          if (issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          chk_tbl   <= tbl_re;
          chk_pnd   <= pnd_re_scan;
          tbl_idx_d <= scan_cnt[TW-1:0];
          if (tbl_hit) begin
            if (cmd_q.op == OP_LOCK) begin
              conflict_seen <= 1'b1;
            end else begin
              entry_valid[tbl_idx_d] <= 1'b0;
              free_count             <= free_count + FW'(1);
            end
          end
          if (pnd_hit) begin
            dup_acc <= 1'b1;
          end
          if (scan_end) begin
            dup_flag[pending_count[PW-1:0]] <= is_dup;
            if (!is_dup) begin
              distinct_count <= distinct_count + PCW'(1);
            end
            pending_count <= pending_count + PCW'(1);
            state         <= cmd_q.last ? ST_FIN : ST_IDLE;
          end
        end
        ST_FIN: begin
          // buffered keys are never in the table here unless a conflict was seen
          if (cmd_q.op == OP_UNLOCK) begin
            status_q <= STATUS_OK;
            state    <= ST_DONE;
          end else if (conflict_seen) begin
            status_q <= STATUS_CONFLICT;
            state    <= ST_DONE;
          end else if (NW'(distinct_count) > NW'(free_count)) begin
            status_q <= STATUS_FULL;
            state    <= ST_DONE;
          end else begin
            status_q <= STATUS_OK;
            ins_p    <= '0;
            ins_t    <= '0;
            state    <= ST_INS_RD;
          end
        end
        ST_INS_RD: begin
          state <= (ins_p == pending_count) ? ST_DONE : ST_INS_WR;
        end
        ST_INS_WR: begin
          if (ins_dup) begin
            ins_p <= ins_p + PCW'(1);
            state <= ST_INS_RD;
          end else if (entry_valid[ins_t]) begin
            ins_t <= ins_t + TW'(1);
          end else begin
            entry_valid[ins_t] <= 1'b1;
            free_count         <= free_count - FW'(1);
            ins_t              <= ins_t + TW'(1);
            ins_p              <= ins_p + PCW'(1);
            state              <= ST_INS_RD;
          end
        end
        ST_DONE: begin
          if (res_ack) begin
            pending_count  <= '0;
            distinct_count <= '0;
            conflict_seen  <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle       = (state == ST_IDLE);
  assign res.valid  = (state == ST_DONE);
  assign res.status = status_q;

  `LKT_ASSERT(a_free_matches_valid, 32'(free_count) + 32'($countones(entry_valid)) == 32'(TABLE_DEPTH), "free count out of step with valid bits")
  `LKT_ASSERT(a_pending_bound, pending_count <= PCW'(MAX_IDS), "pending count beyond limit")
  `LKT_ASSERT_IMP(a_insert_has_room, (state == ST_INS_WR) && !ins_dup, free_count != '0, "insert with no free entry")
  `LKT_ASSERT_NXT(a_done_holds, (state == ST_DONE) && !res_ack, (state == ST_DONE) && $stable(status_q), "result dropped before taken")

endmodule

// ===== hw/rtl/multi_key_lock_table.sv =====
// Top level of the multi-key lock table: stream ports and output register.
//
//  channel  dir  beat contents
//  s_axis   in   tuser opcode, tdata[63:0] inode_key, tlast last_key
//  m_axis   out  tdata[1:0] status (one beat per request, on its last identifier)
//
// A buffered identifier scans SCAN_LEN entries (SCAN_LEN = max(TABLE_DEPTH, MAX_IDS)):
// the key memory and pending buffer are read one entry per cycle.
// An identifier beyond MAX_IDS is not buffered. Every last item passes ST_FIN and ST_DONE;
// a granted lock then walks ST_INS_RD and ST_INS_WR per key, skipping occupied entries.
// Reset clears the valid bits at once; no clearing pass over the key memory.
// s_axis_tready is low while an identifier is in work; the engine holds its result
// while the output register is full and not being taken.
module multi_key_lock_table
  import lkt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // inode_key
  input  logic                   s_axis_tuser,   // opcode
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status, zero pad
);

  lkt_cmd_t    cmd;
  lkt_res_t    res;
  logic        eng_idle;
  logic        start;
  logic        res_ack;
  lkt_status_t out_status;

  always_comb begin
    cmd.op   = lkt_op_t'(s_axis_tuser);
    cmd.key  = s_axis_tdata[KEY_W-1:0];
    cmd.last = s_axis_tlast;
  end

  assign s_axis_tready = eng_idle;
  assign start         = s_axis_tvalid && eng_idle;
  assign res_ack       = res.valid && (!m_axis_tvalid || m_axis_tready);

  lkt_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .idle    (eng_idle),
    .res     (res),
    .res_ack (res_ack)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ack) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_status <= res.status;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W){1'b0}}, out_status};

endmodule

// ===== bench/multi_key_lock_table_tb.sv =====
// Self-checking stream testbench for the multi-key lock table.
`timescale 1ns / 1ps

module multi_key_lock_table_tb;
  import lkt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AT = 3000;
  localparam int HOLD_LEN = 900;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  multi_key_lock_table DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  int cycles = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  wire calm = (cycles >= 6000) && (cycles < 12000);

  lkt_cmd_t pending_cmds[$];
  lkt_cmd_t drv_cmd;
  lkt_status_t expected_status[$];
  lkt_status_t got_status;

  // shadow of the lock table and of the request being collected
  bit tbl_valid [TABLE_DEPTH];
  logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
  logic [KEY_W-1:0] req_keys [MAX_IDS];
  int req_count = 0;
  bit req_conflict = 1'b0;

  function automatic int tbl_find(input logic [KEY_W-1:0] k);
    int s;
    for (s = 0; s < TABLE_DEPTH; s++) begin
      if (tbl_valid[s] && tbl_key[s] == k) return s;
    end
    return -1;
  endfunction

  function automatic lkt_status_t grant_request();
    int needed;
    int free_slots;
    int i;
    int j;
    int s;
    bit fresh;
    bit placed;
    if (req_conflict) return STATUS_CONFLICT;
    needed = 0;
    for (i = 0; i < req_count; i++) begin
      fresh = (tbl_find(req_keys[i]) < 0);
      for (j = 0; j < i; j++) begin
        if (req_keys[j] == req_keys[i]) fresh = 1'b0;
      end
      if (fresh) needed++;
    end
    free_slots = 0;
    for (s = 0; s < TABLE_DEPTH; s++) begin
      if (!tbl_valid[s]) free_slots++;
    end
    if (needed > free_slots) return STATUS_FULL;
    for (i = 0; i < req_count; i++) begin
      if (tbl_find(req_keys[i]) < 0) begin
        placed = 1'b0;
        for (s = 0; s < TABLE_DEPTH && !placed; s++) begin
          if (!tbl_valid[s]) begin
            tbl_valid[s] = 1'b1;
            tbl_key[s] = req_keys[i];
            placed = 1'b1;
          end
        end
      end
    end
    return STATUS_OK;
  endfunction

  task automatic lock_table_step(input lkt_op_t op, input logic [KEY_W-1:0] key,
                                 input logic last);
    int hit;
    hit = tbl_find(key);
    // identifiers past MAX_IDS are dropped, but a last one still closes the request
    if (req_count < MAX_IDS) begin
      if (op == OP_LOCK) begin
        if (hit >= 0) req_conflict = 1'b1;
      end else if (hit >= 0) begin
        tbl_valid[hit] = 1'b0;
      end
      req_keys[req_count] = key;
      req_count++;
    end
    if (last) begin
      if (op == OP_LOCK) expected_status.push_back(grant_request());
      else expected_status.push_back(STATUS_OK);
      req_count = 0;
      req_conflict = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multi_key_lock_table regression: fail");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lock_table_step(drv_cmd.op, drv_cmd.key, drv_cmd.last);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          drv_cmd = pending_cmds.pop_front();
          s_axis_tdata <= IN_TDATA_W'(drv_cmd.key);
          s_axis_tuser <= drv_cmd.op;
          s_axis_tlast <= drv_cmd.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the output register and engine back up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && cycles >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 19);
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = lkt_status_t'(m_axis_tdata[STATUS_W-1:0]);
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual status %0d",
                   $time, got_status);
          mismatches++;
        end else if (got_status != expected_status[0]) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, expected_status[0], got_status);
          mismatches++;
          void'(expected_status.pop_front());
        end else begin
          void'(expected_status.pop_front());
        end
      end
    end
  end

  int items_queued = 0;
  logic [KEY_W-1:0] held_keys[$];

  task automatic send_key(input lkt_op_t op, input logic [KEY_W-1:0] key, input logic last);
    lkt_cmd_t c;
    c.op = op;
    c.key = key;
    c.last = last;
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] take_held();
    int idx;
    logic [KEY_W-1:0] k;
    if (held_keys.size() == 0) return rand_key();
    idx = $urandom_range(held_keys.size() - 1);
    k = held_keys[idx];
    held_keys.delete(idx);
    return k;
  endfunction

  initial begin
    int n;
    int i;
    int kind;
    int pick;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] prev;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme keys, conflict, duplicates, mixed ops, too many ids
    send_key(OP_LOCK, '0, 1'b1);
    send_key(OP_LOCK, '1, 1'b1);
    send_key(OP_LOCK, '0, 1'b1);
    send_key(OP_LOCK, 64'h5, 1'b0);
    send_key(OP_LOCK, 64'h5, 1'b0);
    send_key(OP_LOCK, 64'h5, 1'b1);
    send_key(OP_LOCK, 64'h11, 1'b0);
    send_key(OP_UNLOCK, '1, 1'b0);
    send_key(OP_LOCK, 64'h12, 1'b1);
    for (i = 0; i < 10; i++) send_key(OP_LOCK, 64'h100 + i, i == 9);
    send_key(OP_LOCK, 64'h109, 1'b0);
    send_key(OP_UNLOCK, '0, 1'b0);
    send_key(OP_UNLOCK, 64'h5, 1'b0);
    send_key(OP_UNLOCK, 64'h108, 1'b0);
    send_key(OP_UNLOCK, '1, 1'b1);

    // sender pause until every result is back
    @(negedge clk);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
      @(negedge clk);

    while (items_queued < 424) begin
      // fill the table with eleven requests of mostly fresh keys, so that it can report full
      repeat (11) begin
        n = $urandom_range(8, 6);
        for (i = 0; i < n; i++) begin
          if (i == 0 && held_keys.size() != 0 && $urandom_range(3) == 0) begin
            k = held_keys[$urandom_range(held_keys.size() - 1)];
          end else begin
            k = rand_key();
            held_keys.push_back(k);
          end
          send_key(OP_LOCK, k, i == n - 1);
        end
      end
      // churn: mostly well-formed locks and unlocks, some broken requests
      repeat (10) begin
        kind = $urandom_range(9);
        if (kind <= 3) begin
          n = $urandom_range(MAX_IDS, 1);
          for (i = 0; i < n; i++) send_key(OP_UNLOCK, take_held(), i == n - 1);
        end else if (kind <= 7) begin
          n = $urandom_range(MAX_IDS, 1);
          prev = rand_key();
          for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 15 && i > 0) begin
              k = prev;
            end else if (pick < 30 && held_keys.size() != 0) begin
              k = held_keys[$urandom_range(held_keys.size() - 1)];
            end else begin
              k = rand_key();
              held_keys.push_back(k);
            end
            prev = k;
            send_key(OP_LOCK, k, i == n - 1);
          end
        end else if (kind == 8) begin
          n = $urandom_range(MAX_IDS + 4, MAX_IDS + 1);
          for (i = 0; i < n; i++) begin
            k = rand_key();
            held_keys.push_back(k);
            send_key(OP_LOCK, k, i == n - 1);
          end
        end else begin
          n = $urandom_range(6, 2);
          for (i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0) begin
              k = rand_key();
              held_keys.push_back(k);
              send_key(OP_LOCK, k, i == n - 1);
            end else begin
              send_key(OP_UNLOCK, take_held(), i == n - 1);
            end
          end
        end
      end
      // sweep: release everything believed held
      while (held_keys.size() != 0) begin
        n = (held_keys.size() > MAX_IDS) ? MAX_IDS : held_keys.size();
        for (i = 0; i < n; i++) send_key(OP_UNLOCK, held_keys.pop_front(), i == n - 1);
      end
    end

    @(negedge clk);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("multi_key_lock_table regression: pass");
    end else begin
      $display("multi_key_lock_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== multi_key_lock_table.f =====
+incdir+hw/rtl
hw/rtl/lkt_pkg.sv
hw/rtl/lkt_ram.sv
hw/rtl/lkt_engine.sv
hw/rtl/multi_key_lock_table.sv
bench/multi_key_lock_table_tb.sv
